// ----- hdl/ffhl_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit hole list allocator package
// Shared constants, payload types, codes and small helpers for the hole list
// allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffhl_pkg;

  // Table geometry and click address width.
  localparam int unsigned HOLE_ENTRIES    = 64;
  localparam int unsigned CLICK_ADDR_BITS = 20;
  localparam int unsigned LIMIT_BITS      = CLICK_ADDR_BITS + 1;

  // A slot index addresses the table; a link can also hold the nil code.
  localparam int unsigned SLOT_W = $clog2(HOLE_ENTRIES);
  localparam int unsigned LINK_W = $clog2(HOLE_ENTRIES + 1);

  typedef logic [CLICK_ADDR_BITS-1:0] click_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [LINK_W-1:0]          link_t;
  typedef logic [LIMIT_BITS-1:0]      limit_t;

  // Nil is coded as one past the last slot.
  localparam link_t  NIL_SLOT    = LINK_W'(HOLE_ENTRIES);
  localparam limit_t LIMIT_RESET = LIMIT_BITS'(1) << CLICK_ADDR_BITS;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_MEM     = 2'd1,
    STATUS_TABLE_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_ADD_SAT
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_CHK,
    ST_A_BITE,
    ST_A_REL1,
    ST_A_REL2,
    ST_F_SPARE,
    ST_F_WALK,
    ST_F_LINKF,
    ST_F_LINKP,
    ST_M_START,
    ST_M_LOAD,
    ST_M_CMP,
    ST_M_SUM,
    ST_M_REL1,
    ST_M_REL2,
    ST_DONE
  } state_e;

  typedef struct packed {
    mode_e  mode;
    click_t block_base;
    click_t block_clicks;
  } in_t;

  typedef struct packed {
    click_t  granted_base;
    status_e status;
  } out_t;

  // One table entry: base and length of a free hole.
  typedef struct packed {
    click_t start;
    click_t size;
  } hole_t;

  // Result of the shared adder: carry out (or "no borrow" on subtract).
  typedef struct packed {
    logic   carry;
    click_t value;
  } alu_res_t;

  // A link names a slot only when it is below the nil code.
  function automatic logic is_slot(link_t s);
    return s < NIL_SLOT;
  endfunction

  function automatic slot_t slot_of(link_t s);
    return s[SLOT_W-1:0];
  endfunction

  // Link of a slot that was never written: the next slot, the last one to nil.
  function automatic link_t default_link(slot_t s);
    return LINK_W'(s) + LINK_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ffhl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered. A read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ffhl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array with a registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/ffhl_alu.sv -----
// ----------------------------------------------------------------------------
// Hole list shared adder
// One add/subtract unit used by the sequencer for size checks, base bites,
// touching tests and saturating merges.
// ----------------------------------------------------------------------------
`default_nettype none

module ffhl_alu (
  input  wire ffhl_pkg::alu_op_e op_i,
  input  wire ffhl_pkg::click_t  a_i,
  input  wire ffhl_pkg::click_t  b_i,
  output ffhl_pkg::alu_res_t     res_o
);

  localparam int unsigned W = ffhl_pkg::CLICK_ADDR_BITS;

  logic         sub;
  logic [W:0]   b_ext;
  logic [W:0]   sum;

  // Subtract is a + ~b + 1; the top bit is then set when a >= b.
  always_comb begin
    sub   = (op_i == ffhl_pkg::ALU_SUB);
    b_ext = sub ? {1'b0, ~b_i} : {1'b0, b_i};
    sum   = {1'b0, a_i} + b_ext + {{W{1'b0}}, sub};
  end

  // Saturating add clamps to the largest click count on overflow.
  always_comb begin
    res_o.carry = sum[W];
    if (op_i == ffhl_pkg::ALU_ADD_SAT && sum[W]) begin
      res_o.value = '1;
    end else begin
      res_o.value = sum[W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ffhl_link_store.sv -----
// ----------------------------------------------------------------------------
// Hole list link store
// Next-slot links of the hole table. A slot never written reads as its
// reset link (the following slot, the last one to nil) by way of valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ffhl_link_store (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire ffhl_pkg::slot_t   waddr_i,
  input  wire ffhl_pkg::link_t   wdata_i,
  input  wire ffhl_pkg::slot_t   raddr_i,
  output ffhl_pkg::link_t        rdata_o
);

  logic [ffhl_pkg::HOLE_ENTRIES-1:0] valid_q, valid_d;
  logic                              hit_q;
  ffhl_pkg::slot_t                   raddr_q;
  ffhl_pkg::link_t                   ram_rdata;

  ffhl_ram #(
    .WIDTH (ffhl_pkg::LINK_W),
    .DEPTH (ffhl_pkg::HOLE_ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // Mark a slot as written.
  always_comb begin
    valid_d = valid_q;
    if (we_i) begin
      valid_d[waddr_i] = 1'b1;
    end
  end

  // Valid bits clear at reset; the hit and address follow the RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= valid_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_i;
  end

  assign rdata_o = hit_q ? ram_rdata : ffhl_pkg::default_link(raddr_q);

endmodule

`default_nettype wire

// ----- hdl/first_fit_hole_list_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit hole list allocator
// Keeps a table of free holes as a base-sorted linked list plus a list of
// spare slots. Allocate walks the list first-fit below a configured limit and
// bites the request off the front of a hole; free inserts a hole in address
// order and merges it with touching neighbors.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Beat
//  in        input      in_valid_i/stall_o   in_t: mode, block_base, block_clicks
//  out       output     out_valid_o/stall_i  out_t: granted_base, status
//  cfg       input      cfg_valid_i/ready_o  search_limit (always ready)
//
//  Allocate visits the holes of the list in order until the first fit, at most
//  all of a full 64-entry table. Free examines holes to find its place, then
//  inserts and merges; since a free needs a spare slot, it walks at most 63
//  holes. The list walk does one hole and link RAM read per cycle and uses
//  one shared adder. The input is stalled while an item is in work; a
//  finished result sits in the output register, so the next item is taken
//  while it waits. Reset needs no clearing pass: link valid bits clear at reset.
//
`default_nettype none

module first_fit_hole_list_allocator (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire ffhl_pkg::in_t           in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output ffhl_pkg::out_t               out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire ffhl_pkg::limit_t        cfg_data_i
);

  // State and registers.
  ffhl_pkg::state_e   state_q, state_d;
  ffhl_pkg::click_t   base_q, base_d;
  ffhl_pkg::click_t   clicks_q, clicks_d;
  ffhl_pkg::link_t    cur_q, cur_d;
  ffhl_pkg::link_t    prev_q, prev_d;
  ffhl_pkg::link_t    fresh_q, fresh_d;
  ffhl_pkg::slot_t    steps_q, steps_d;
  ffhl_pkg::click_t   start_q, start_d;
  ffhl_pkg::click_t   size_q, size_d;
  ffhl_pkg::link_t    link_q, link_d;
  ffhl_pkg::click_t   nsize_q, nsize_d;
  ffhl_pkg::link_t    nlink_q, nlink_d;
  logic               pass_q, pass_d;
  ffhl_pkg::out_t     res_q, res_d;
  logic               out_valid_q, out_valid_d;
  ffhl_pkg::out_t     out_q, out_d;
  ffhl_pkg::link_t    list_head_q, list_head_d;
  ffhl_pkg::link_t    spare_head_q, spare_head_d;
  ffhl_pkg::limit_t   limit_q, limit_d;

  // Memory ports and the shared adder.
  ffhl_pkg::slot_t    rd_slot;
  ffhl_pkg::hole_t    hole_rd;
  logic               hole_we;
  ffhl_pkg::slot_t    hole_wslot;
  ffhl_pkg::hole_t    hole_wdata;
  ffhl_pkg::link_t    link_rd;
  logic               link_we;
  ffhl_pkg::slot_t    link_wslot;
  ffhl_pkg::link_t    link_wdata;
  ffhl_pkg::alu_op_e  alu_op;
  ffhl_pkg::click_t   alu_a;
  ffhl_pkg::click_t   alu_b;
  ffhl_pkg::alu_res_t alu_res;

  // Decoded conditions.
  logic accept;
  logic in_free;
  logic clicks_zero;
  logic head_slot;
  logic spare_slot;
  logic rd_link_slot;
  logic step_last;
  logic above_limit;
  logic touch;
  logic out_free;
  ffhl_pkg::state_e cont_state;

  ffhl_ram #(
    .WIDTH ($bits(ffhl_pkg::hole_t)),
    .DEPTH (ffhl_pkg::HOLE_ENTRIES)
  ) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (hole_we),
    .waddr_i (hole_wslot),
    .wdata_i (hole_wdata),
    .raddr_i (rd_slot),
    .rdata_o (hole_rd)
  );

  ffhl_link_store u_link_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (link_we),
    .waddr_i (link_wslot),
    .wdata_i (link_wdata),
    .raddr_i (rd_slot),
    .rdata_o (link_rd)
  );

  ffhl_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Handshake outputs.
  assign in_stall_o  = (state_q != ffhl_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Conditions shared by the next-state and datapath logic.
  assign accept       = in_valid_i && !in_stall_o;
  assign in_free      = (in_data_i.mode == ffhl_pkg::MODE_FREE);
  assign clicks_zero  = (in_data_i.block_clicks == '0);
  assign head_slot    = ffhl_pkg::is_slot(list_head_q);
  assign spare_slot   = ffhl_pkg::is_slot(spare_head_q);
  assign rd_link_slot = ffhl_pkg::is_slot(link_rd);
  assign step_last    = (steps_q == ffhl_pkg::SLOT_W'(ffhl_pkg::HOLE_ENTRIES - 1));
  assign above_limit  = ({1'b0, hole_rd.start} >= limit_q);
  assign touch        = ({alu_res.carry, alu_res.value} == {1'b0, hole_rd.start});
  assign out_free     = !out_valid_q || !out_stall_i;

  // After a merge release: try the second absorb or finish.
  always_comb begin
    if (pass_q || !ffhl_pkg::is_slot(nlink_q)) begin
      cont_state = ffhl_pkg::ST_DONE;
    end else begin
      cont_state = ffhl_pkg::ST_M_CMP;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffhl_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_free) begin
            state_d = head_slot ? ffhl_pkg::ST_A_CHK : ffhl_pkg::ST_DONE;
          end else if (clicks_zero || !spare_slot) begin
            state_d = ffhl_pkg::ST_DONE;
          end else begin
            state_d = ffhl_pkg::ST_F_SPARE;
          end
        end
      end
      ffhl_pkg::ST_A_CHK: begin
        if (above_limit) begin
          state_d = ffhl_pkg::ST_DONE;
        end else if (alu_res.carry) begin
          state_d = ffhl_pkg::ST_A_BITE;
        end else if (!rd_link_slot || step_last) begin
          state_d = ffhl_pkg::ST_DONE;
        end
      end
      ffhl_pkg::ST_A_BITE: begin
        state_d = (size_q == '0) ? ffhl_pkg::ST_A_REL1 : ffhl_pkg::ST_DONE;
      end
      ffhl_pkg::ST_A_REL1: begin
        if (cur_q == list_head_q || !ffhl_pkg::is_slot(prev_q)) begin
          state_d = ffhl_pkg::ST_DONE;
        end else begin
          state_d = ffhl_pkg::ST_A_REL2;
        end
      end
      ffhl_pkg::ST_A_REL2: begin
        state_d = ffhl_pkg::ST_DONE;
      end
      ffhl_pkg::ST_F_SPARE: begin
        state_d = ffhl_pkg::is_slot(cur_q) ? ffhl_pkg::ST_F_WALK : ffhl_pkg::ST_F_LINKF;
      end
      ffhl_pkg::ST_F_WALK: begin
        if (alu_res.carry || !rd_link_slot || step_last) begin
          state_d = ffhl_pkg::ST_F_LINKF;
        end
      end
      ffhl_pkg::ST_F_LINKF: begin
        state_d = ffhl_pkg::is_slot(prev_q) ? ffhl_pkg::ST_F_LINKP : ffhl_pkg::ST_M_START;
      end
      ffhl_pkg::ST_F_LINKP: begin
        state_d = ffhl_pkg::ST_M_START;
      end
      ffhl_pkg::ST_M_START: begin
        state_d = ffhl_pkg::ST_M_LOAD;
      end
      ffhl_pkg::ST_M_LOAD: begin
        state_d = rd_link_slot ? ffhl_pkg::ST_M_CMP : ffhl_pkg::ST_DONE;
      end
      ffhl_pkg::ST_M_CMP: begin
        if (touch) begin
          state_d = ffhl_pkg::ST_M_SUM;
        end else if (pass_q || !rd_link_slot) begin
          state_d = ffhl_pkg::ST_DONE;
        end
      end
      ffhl_pkg::ST_M_SUM: begin
        state_d = ffhl_pkg::ST_M_REL1;
      end
      ffhl_pkg::ST_M_REL1: begin
        state_d = (link_q == list_head_q) ? cont_state : ffhl_pkg::ST_M_REL2;
      end
      ffhl_pkg::ST_M_REL2: begin
        state_d = cont_state;
      end
      ffhl_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ffhl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffhl_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, memory and adder control.
  always_comb begin
    base_d       = base_q;
    clicks_d     = clicks_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    fresh_d      = fresh_q;
    steps_d      = steps_q;
    start_d      = start_q;
    size_d       = size_q;
    link_d       = link_q;
    nsize_d      = nsize_q;
    nlink_d      = nlink_q;
    pass_d       = pass_q;
    res_d        = res_q;
    out_d        = out_q;
    list_head_d  = list_head_q;
    spare_head_d = spare_head_q;
    limit_d      = limit_q;
    rd_slot      = ffhl_pkg::slot_of(cur_q);
    hole_we      = 1'b0;
    hole_wslot   = ffhl_pkg::slot_of(cur_q);
    hole_wdata   = '{start: start_q, size: size_q};
    link_we      = 1'b0;
    link_wslot   = ffhl_pkg::slot_of(cur_q);
    link_wdata   = spare_head_q;
    alu_op       = ffhl_pkg::ALU_ADD;
    alu_a        = start_q;
    alu_b        = clicks_q;

    // Output register: a taken beat frees it.
    out_valid_d = out_valid_q && out_stall_i;

    // Configuration writes land at any time.
    if (cfg_valid_i && cfg_ready_o) begin
      limit_d = cfg_data_i;
    end

    case (state_q)
      // Take an item and start its first read.
      ffhl_pkg::ST_IDLE: begin
        if (accept) begin
          base_d   = in_data_i.block_base;
          clicks_d = in_data_i.block_clicks;
          cur_d    = list_head_q;
          prev_d   = ffhl_pkg::NIL_SLOT;
          steps_d  = '0;
          pass_d   = 1'b0;
          res_d    = '{granted_base: '0, status: ffhl_pkg::STATUS_OK};
          if (!in_free) begin
            rd_slot = ffhl_pkg::slot_of(list_head_q);
            if (!head_slot) begin
              res_d.status = ffhl_pkg::STATUS_NO_MEM;
            end
          end else if (!clicks_zero) begin
            if (!spare_slot) begin
              res_d.status = ffhl_pkg::STATUS_TABLE_FULL;
            end else begin
              hole_we    = 1'b1;
              hole_wslot = ffhl_pkg::slot_of(spare_head_q);
              hole_wdata = '{start: in_data_i.block_base, size: in_data_i.block_clicks};
              rd_slot    = ffhl_pkg::slot_of(spare_head_q);
              fresh_d    = spare_head_q;
            end
          end
        end
      end

      // First-fit check of one hole; step on to the next link if it is short.
      ffhl_pkg::ST_A_CHK: begin
        alu_op  = ffhl_pkg::ALU_SUB;
        alu_a   = hole_rd.size;
        alu_b   = clicks_q;
        start_d = hole_rd.start;
        size_d  = alu_res.value;
        link_d  = link_rd;
        if (above_limit) begin
          res_d.status = ffhl_pkg::STATUS_NO_MEM;
        end else if (!alu_res.carry) begin
          prev_d  = cur_q;
          cur_d   = link_rd;
          steps_d = steps_q + ffhl_pkg::SLOT_W'(1);
          rd_slot = ffhl_pkg::slot_of(link_rd);
          if (!rd_link_slot || step_last) begin
            res_d.status = ffhl_pkg::STATUS_NO_MEM;
          end
        end
      end

      // Bite the request off the front of the hole.
      ffhl_pkg::ST_A_BITE: begin
        alu_op     = ffhl_pkg::ALU_ADD;
        alu_a      = start_q;
        alu_b      = clicks_q;
        hole_we    = 1'b1;
        hole_wdata = '{start: alu_res.value, size: size_q};
        res_d      = '{granted_base: start_q, status: ffhl_pkg::STATUS_OK};
      end

      // Emptied hole: unlink it and push its slot on the spare list.
      ffhl_pkg::ST_A_REL1: begin
        link_we      = 1'b1;
        link_wdata   = spare_head_q;
        spare_head_d = cur_q;
        if (cur_q == list_head_q || !ffhl_pkg::is_slot(prev_q)) begin
          list_head_d = link_q;
        end
      end

      ffhl_pkg::ST_A_REL2: begin
        link_we    = 1'b1;
        link_wslot = ffhl_pkg::slot_of(prev_q);
        link_wdata = link_q;
      end

      // Pop the fresh slot off the spare list and start the insert walk.
      ffhl_pkg::ST_F_SPARE: begin
        spare_head_d = link_rd;
      end

      // Walk past holes whose base is below the freed block.
      ffhl_pkg::ST_F_WALK: begin
        alu_op = ffhl_pkg::ALU_SUB;
        alu_a  = hole_rd.start;
        alu_b  = base_q;
        if (!alu_res.carry) begin
          prev_d  = cur_q;
          cur_d   = link_rd;
          steps_d = steps_q + ffhl_pkg::SLOT_W'(1);
          rd_slot = ffhl_pkg::slot_of(link_rd);
        end
      end

      // Link the fresh hole in front of the stop point.
      ffhl_pkg::ST_F_LINKF: begin
        link_we    = 1'b1;
        link_wslot = ffhl_pkg::slot_of(fresh_q);
        link_wdata = ffhl_pkg::is_slot(cur_q) ? cur_q : ffhl_pkg::NIL_SLOT;
        if (!ffhl_pkg::is_slot(prev_q)) begin
          list_head_d = fresh_q;
          cur_d       = fresh_q;
        end
      end

      ffhl_pkg::ST_F_LINKP: begin
        link_we    = 1'b1;
        link_wslot = ffhl_pkg::slot_of(prev_q);
        link_wdata = fresh_q;
        cur_d      = prev_q;
      end

      // Merge run: load the first hole, then read its successor.
      ffhl_pkg::ST_M_START: begin
        rd_slot = ffhl_pkg::slot_of(cur_q);
      end

      ffhl_pkg::ST_M_LOAD: begin
        start_d = hole_rd.start;
        size_d  = hole_rd.size;
        link_d  = link_rd;
        rd_slot = ffhl_pkg::slot_of(link_rd);
      end

      // Touching test: end of the current hole against the successor's base.
      ffhl_pkg::ST_M_CMP: begin
        alu_op  = ffhl_pkg::ALU_ADD;
        alu_a   = start_q;
        alu_b   = size_q;
        nsize_d = hole_rd.size;
        nlink_d = link_rd;
        if (!touch && !pass_q) begin
          pass_d  = 1'b1;
          cur_d   = link_q;
          start_d = hole_rd.start;
          size_d  = hole_rd.size;
          link_d  = link_rd;
          rd_slot = ffhl_pkg::slot_of(link_rd);
        end
      end

      // Absorb the successor with a saturating length.
      ffhl_pkg::ST_M_SUM: begin
        alu_op     = ffhl_pkg::ALU_ADD_SAT;
        alu_a      = size_q;
        alu_b      = nsize_q;
        hole_we    = 1'b1;
        hole_wdata = '{start: start_q, size: alu_res.value};
        size_d     = alu_res.value;
      end

      // Give the absorbed slot back to the spare list.
      ffhl_pkg::ST_M_REL1: begin
        link_we      = 1'b1;
        link_wslot   = ffhl_pkg::slot_of(link_q);
        link_wdata   = spare_head_q;
        spare_head_d = link_q;
        if (link_q == list_head_q) begin
          list_head_d = nlink_q;
          link_d      = nlink_q;
          pass_d      = 1'b1;
          rd_slot     = ffhl_pkg::slot_of(nlink_q);
        end
      end

      ffhl_pkg::ST_M_REL2: begin
        link_we    = 1'b1;
        link_wdata = nlink_q;
        link_d     = nlink_q;
        pass_d     = 1'b1;
        rd_slot    = ffhl_pkg::slot_of(nlink_q);
      end

      // Hand the result to the output register once it is free.
      ffhl_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end

      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ffhl_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      list_head_q  <= ffhl_pkg::NIL_SLOT;
      spare_head_q <= '0;
      limit_q      <= ffhl_pkg::LIMIT_RESET;
      pass_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      list_head_q  <= list_head_d;
      spare_head_q <= spare_head_d;
      limit_q      <= limit_d;
      pass_q       <= pass_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    clicks_q <= clicks_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    fresh_q  <= fresh_d;
    steps_q  <= steps_d;
    start_q  <= start_d;
    size_q   <= size_d;
    link_q   <= link_d;
    nsize_q  <= nsize_d;
    nlink_q  <= nlink_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // The hole list and the spare list never share their first slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ffhl_pkg::is_slot(list_head_q) |-> (list_head_q != spare_head_q))
    else $error("hole list head and spare list head coincide");

  // A walk or merge only ever visits a real slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffhl_pkg::ST_A_CHK || state_q == ffhl_pkg::ST_F_WALK ||
     state_q == ffhl_pkg::ST_M_CMP || state_q == ffhl_pkg::ST_M_SUM)
    |-> ffhl_pkg::is_slot(cur_q))
    else $error("list walk reached a nil slot");

  // Only a successful allocation carries a nonzero base.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ffhl_pkg::STATUS_OK)
    |-> (out_data_o.granted_base == '0))
    else $error("failed result carries a base");

  // A free into a full table reports the table-full status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_free && !clicks_zero && !spare_slot)
    |=> (res_q.status == ffhl_pkg::STATUS_TABLE_FULL && state_q == ffhl_pkg::ST_DONE))
    else $error("free into a full table not flagged");

endmodule

`default_nettype wire
